// ===== src/npc_pkg.sv =====
// Shared types and constants for the nearest palette color search.
// Used by the channel interfaces and every module of the block but npc_ram; no dependencies.
`default_nettype none

package npc_pkg;

  localparam int PALETTE_DEPTH = 64;
  localparam int ADDR_W        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
  localparam int ACTIVE_W      = 7;
  localparam int COLOR_W       = 8;
  localparam int SLOT_W        = 6;
  localparam int DIST_W        = 18;
  localparam int SQ_W          = 2 * COLOR_W;
  localparam int QDEPTH        = 4;
  localparam int QPTR_W        = $clog2(QDEPTH);
  localparam int DIST_MAX      = 195075;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [ACTIVE_W-1:0] active_t;
  typedef logic [COLOR_W-1:0]  color_t;
  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [DIST_W-1:0]   dist_t;
  typedef logic [QPTR_W:0]     fill_t;

  typedef struct packed {
    color_t red;
    color_t green;
    color_t blue;
  } rgb_t;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_QUERY,
    CMD_SKIP
  } kind_t;

  typedef struct packed {
    kind_t kind;
    addr_t slot;
    rgb_t  color;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FLUSH,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== src/npc_if.sv =====
// Valid/ready channel interfaces for request items and response items.
// Depends on npc_pkg for the field types.
`default_nettype none

interface npc_req_if;
  logic            valid;
  logic            ready;
  logic            op;
  npc_pkg::slot_t  entry_index;
  npc_pkg::color_t red;
  npc_pkg::color_t green;
  npc_pkg::color_t blue;

  modport source (output valid, op, entry_index, red, green, blue, input ready);
  modport sink   (input valid, op, entry_index, red, green, blue, output ready);
endinterface

interface npc_rsp_if;
  logic           valid;
  logic           ready;
  npc_pkg::slot_t nearest_index;
  logic           found;
  npc_pkg::dist_t distance_squared;

  modport source (output valid, nearest_index, found, distance_squared, input ready);
  modport sink   (input valid, nearest_index, found, distance_squared, output ready);
endinterface

`default_nettype wire

// ===== src/npc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module npc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/npc_front.sv =====
// Front end: accepts request transfers, classifies them and queues commands.
// Depends on npc_pkg and npc_req_if.
`default_nettype none

module npc_front (
  input  wire logic     clk,
  input  wire logic     rst,
  npc_req_if.sink       req,
  output      logic     q_valid,
  output      npc_pkg::cmd_t q_cmd,
  input  wire logic     q_pop,
  output      npc_pkg::fill_t q_fill
);

  import npc_pkg::*;

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  fill_t             fill;
  cmd_t              cmd_in;
  logic              push;
  logic              pop;

  // Writes beyond the palette are dropped by the back end.
  always_comb begin
    cmd_in.slot  = ADDR_W'(req.entry_index);
    cmd_in.color = '{red: req.red, green: req.green, blue: req.blue};
    if (req.op == OP_QUERY) begin
      cmd_in.kind = CMD_QUERY;
    end else if (32'(req.entry_index) < PALETTE_DEPTH) begin
      cmd_in.kind = CMD_WRITE;
    end else begin
      cmd_in.kind = CMD_SKIP;
    end
  end

  assign req.ready = (fill != fill_t'(QDEPTH));
  assign push      = req.valid && req.ready;
  assign q_valid   = (fill != '0);
  assign pop       = q_pop && q_valid;
  assign q_cmd     = slots[rptr];
  assign q_fill    = fill;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= cmd_in;
    end
  end

  // Pointers wrap naturally: queue depth is a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + fill_t'(1);
        2'b01:   fill <= fill - fill_t'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/npc_back.sv =====
// Back end: executes queued commands against the palette RAM and runs the
// nearest-entry search, one entry per cycle. Depends on npc_pkg, npc_rsp_if, npc_ram.
`default_nettype none

module npc_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire npc_pkg::cnt_t active_cnt,
  input  wire logic          q_valid,
  input  wire npc_pkg::cmd_t q_cmd,
  output      logic          q_pop,
  npc_rsp_if.source          rsp
);

  import npc_pkg::*;

  function automatic logic [SQ_W-1:0] sq_diff(input color_t a, input color_t b);
    color_t d;
    d = (a >= b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

  state_t state;
  state_t state_next;

  logic   ram_we;
  logic   ram_re;
  rgb_t   ram_rdata;
  logic   start;
  logic   load_out;
  logic   issue_last;

  addr_t  cur;
  cnt_t   count;
  rgb_t   qcolor;

  logic   s1_valid;
  addr_t  s1_idx;
  logic   s1_last;

  logic            s2_valid;
  addr_t           s2_idx;
  logic            s2_last;
  logic [SQ_W-1:0] s2_sq_r;
  logic [SQ_W-1:0] s2_sq_g;
  logic [SQ_W-1:0] s2_sq_b;
  dist_t           s2_dist;

  logic   have;
  addr_t  best_idx;
  dist_t  best_dist;
  logic   acc_done;

  logic   out_valid;
  slot_t  out_idx;
  logic   out_found;
  dist_t  out_dist;

  npc_ram #(
    .WIDTH ($bits(rgb_t)),
    .DEPTH (PALETTE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_cmd.slot),
    .wdata (q_cmd.color),
    .re    (ram_re),
    .raddr (cur),
    .rdata (ram_rdata)
  );

  assign issue_last = (CNT_W'(cur) == count - CNT_W'(1));
  assign s2_dist    = DIST_W'(s2_sq_r) + DIST_W'(s2_sq_g) + DIST_W'(s2_sq_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    start      = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_cmd.kind)
            CMD_WRITE: ram_we = 1'b1;
            CMD_QUERY: begin
              start      = 1'b1;
              state_next = (active_cnt == '0) ? ST_DONE : ST_SEARCH;
            end
            default: ;
          endcase
        end
      end
      ST_SEARCH: begin
        ram_re = 1'b1;
        if (issue_last) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (acc_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hold the result until the output register is free.
        if (!out_valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Address sequencing and the two search stages.
  always_ff @(posedge clk) begin
    if (start) begin
      cur    <= '0;
      count  <= active_cnt;
      qcolor <= q_cmd.color;
    end else if (ram_re) begin
      cur <= cur + ADDR_W'(1);
    end
    s1_idx  <= cur;
    s1_last <= issue_last;
    s2_idx  <= s1_idx;
    s2_last <= s1_last;
    s2_sq_r <= sq_diff(qcolor.red,   ram_rdata.red);
    s2_sq_g <= sq_diff(qcolor.green, ram_rdata.green);
    s2_sq_b <= sq_diff(qcolor.blue,  ram_rdata.blue);
  end

  // Keep the running best; ties go to the later entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      have      <= 1'b0;
      acc_done  <= 1'b0;
      best_idx  <= '0;
      best_dist <= '0;
    end else begin
      s1_valid <= ram_re;
      s2_valid <= s1_valid;
      if (start) begin
        have      <= 1'b0;
        acc_done  <= 1'b0;
        best_idx  <= '0;
        best_dist <= '0;
      end else if (s2_valid) begin
        if (!have || s2_dist <= best_dist) begin
          best_idx  <= s2_idx;
          best_dist <= s2_dist;
        end
        have <= 1'b1;
        if (s2_last) begin
          acc_done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_idx   <= SLOT_W'(best_idx);
      out_found <= have;
      out_dist  <= best_dist;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.nearest_index    = out_idx;
  assign rsp.found            = out_found;
  assign rsp.distance_squared = out_dist;

endmodule

`default_nettype wire

// ===== src/nearest_palette_color.sv =====
// Nearest palette color search (squared RGB distance).
// Channels: req (sink, valid/ready) carries palette writes (op 0) and color
//   queries (op 1); rsp (source, valid/ready) returns one result per query,
//   none per write. cfg_we/cfg_wdata load active_entries (capped at 64).
// Request transfers enter a four-command queue; the back end drains it in
//   order, so the sender keeps going while a search runs.
// A query is paced by the single read port of the palette RAM (one entry per
//   cycle) and feeds a two-stage distance pipe; with no active entries to
//   search, it skips the search and goes straight to the result.
// A receiver stall holds the result in the output register; the back end
//   waits only when the next result is ready, and the queue fills and drops
//   req.ready after four further commands.
// Reset (rst, synchronous) empties the queue and clears active_entries; the
//   palette contents stay undefined until written.
// Depends on npc_pkg, npc_if, npc_front, npc_back.
`default_nettype none

module nearest_palette_color (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire npc_pkg::active_t cfg_wdata,
  npc_req_if.sink               req,
  npc_rsp_if.source             rsp
);

  import npc_pkg::*;

  active_t active_entries;
  cnt_t    active_cnt;
  logic    q_valid;
  cmd_t    q_cmd;
  logic    q_pop;
  fill_t   q_fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_entries <= '0;
    end else if (cfg_we) begin
      active_entries <= cfg_wdata;
    end
  end

  // Clamp the count to the palette size.
  assign active_cnt = (32'(active_entries) > PALETTE_DEPTH) ?
                      CNT_W'(PALETTE_DEPTH) : CNT_W'(active_entries);

  npc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .q_fill  (q_fill)
  );

  npc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .active_cnt (active_cnt),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .rsp        (rsp)
  );

`ifndef ASSERT_OFF
  a_empty_result : assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.found |-> rsp.nearest_index == '0 && rsp.distance_squared == '0)
    else $error("empty search returned nonzero fields");

  a_index_range : assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.found |-> CNT_W'(rsp.nearest_index) < active_cnt)
    else $error("nearest index outside the searched entries");

  a_dist_range : assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> 32'(rsp.distance_squared) <= DIST_MAX)
    else $error("distance above the largest possible RGB distance");

  a_queue_full : assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> q_fill == fill_t'(QDEPTH) && q_valid)
    else $error("request stalled while the queue has room");
`endif

endmodule

`default_nettype wire

// ===== dv/npc_result_checker.sv =====
// Result checker for nearest_palette_color: watches config, request and response transfers.
// Keeps its own palette copy and search length, predicts each query result and compares.
// Depends on npc_pkg and the npc_req_if / npc_rsp_if channel interfaces.
`timescale 1ns / 100ps

module npc_result_checker
  import npc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    cfg_we,
  input  active_t cfg_wdata,
  npc_req_if      req,
  npc_rsp_if      rsp,
  output int      errors,
  output int      pending,
  output int      queries_seen,
  output int      matches_seen
);

  typedef struct packed {
    slot_t nearest_index;
    logic  found;
    dist_t distance_squared;
  } nearest_t;

  rgb_t     pal_copy [PALETTE_DEPTH];
  active_t  search_len;
  nearest_t nearest_q [$];

  function automatic int unsigned sq_gap(color_t a, color_t b);
    int unsigned d;
    d = (a >= b) ? a - b : b - a;
    return d * d;
  endfunction

  // Scan entries in order; <= lets the later entry win on equal distance.
  function automatic nearest_t search_palette(rgb_t c);
    nearest_t    res;
    int unsigned n;
    int unsigned d;
    int unsigned best;
    bit          have;
    res  = '0;
    best = 0;
    have = 1'b0;
    n    = (search_len > PALETTE_DEPTH) ? PALETTE_DEPTH : search_len;
    for (int unsigned i = 0; i < n; i++) begin
      d = sq_gap(c.red, pal_copy[i].red) + sq_gap(c.green, pal_copy[i].green)
        + sq_gap(c.blue, pal_copy[i].blue);
      if (!have || d <= best) begin
        have              = 1'b1;
        best              = d;
        res.nearest_index = slot_t'(i);
      end
    end
    res.found            = have;
    res.distance_squared = dist_t'(best);
    return res;
  endfunction

  always @(posedge clk) begin : watch
    nearest_t want;
    if (rst) begin
      nearest_q.delete();
      search_len = '0;
    end else begin
      if (cfg_we) search_len = cfg_wdata;
      if (req.valid && req.ready) begin
        if (req.op == OP_WRITE) begin
          pal_copy[req.entry_index] = {req.red, req.green, req.blue};
        end else begin
          want = search_palette({req.red, req.green, req.blue});
          nearest_q.push_back(want);
          queries_seen++;
          if (want.found) matches_seen++;
        end
      end
      if (rsp.valid && rsp.ready) begin
        if (nearest_q.size() == 0) begin
          $error("result with none pending: nearest_index %0d found %0b distance_squared %0d",
                 rsp.nearest_index, rsp.found, rsp.distance_squared);
          errors++;
        end else begin
          want = nearest_q.pop_front();
          if (rsp.nearest_index !== want.nearest_index) begin
            $error("nearest_index: expected %0d, got %0d", want.nearest_index,
                   rsp.nearest_index);
            errors++;
          end
          if (rsp.found !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, rsp.found);
            errors++;
          end
          if (rsp.distance_squared !== want.distance_squared) begin
            $error("distance_squared: expected %0d, got %0d", want.distance_squared,
                   rsp.distance_squared);
            errors++;
          end
        end
      end
    end
    pending = nearest_q.size();
  end

endmodule

// ===== dv/tb.sv =====
// Testbench top for nearest_palette_color: clock, reset, palette writes, queries and config.
// Depends on npc_pkg, the channel interfaces, the block and npc_result_checker.
`timescale 1ns / 100ps

module tb;
  import npc_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 55;
  localparam int TIMEOUT_NS    = 5_000_000;

  localparam rgb_t BLACK = '0;
  localparam rgb_t WHITE = '1;
  localparam rgb_t RED   = {8'hff, 8'h00, 8'h00};

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    cfg_we;
  active_t cfg_wdata;

  int mismatches;
  int awaited;
  int queries_seen;
  int matches_seen;

  int items_sent   = 0;
  int holds_asked  = 0;
  int holds_done   = 0;
  bit rsp_calm     = 1'b0;
  bit req_calm     = 1'b0;
  int unsigned live = 0;

  // Colors written so far, used to steer queries near real entries and to repeat colors in writes.
  rgb_t shadow [PALETTE_DEPTH];

  npc_req_if req_ch ();
  npc_rsp_if rsp_ch ();

  nearest_palette_color u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  npc_result_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .errors       (mismatches),
    .pending      (awaited),
    .queries_seen (queries_seen),
    .matches_seen (matches_seen)
  );

  always #6 clk = ~clk;

  initial begin
    #TIMEOUT_NS;
    $display("tb: FAIL");
    $finish;
  end

  function automatic color_t pick_level();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return color_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic rgb_t pick_color();
    rgb_t c;
    c.red   = pick_level();
    c.green = pick_level();
    c.blue  = pick_level();
    return c;
  endfunction

  function automatic color_t nudge(color_t v);
    int n;
    n = int'(v) + int'($urandom_range(0, 12)) - 6;
    if (n < 0) n = 0;
    if (n > 255) n = 255;
    return color_t'(n);
  endfunction

  // Mostly aim near live entries so close calls and exact hits happen.
  function automatic rgb_t pick_query();
    rgb_t        c;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (live == 0 || roll < 40) return pick_color();
    c = shadow[$urandom_range(0, live - 1)];
    if (roll >= 55) begin
      c.red   = nudge(c.red);
      c.green = nudge(c.green);
      c.blue  = nudge(c.blue);
    end
    return c;
  endfunction

  // Keep valid high across back-to-back items; drop it only for a gap.
  task automatic send_item(logic op, slot_t idx, rgb_t c);
    if (!req_calm && $urandom_range(0, 99) < 24) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 24);
    end
    req_ch.valid       <= 1'b1;
    req_ch.op          <= op;
    req_ch.entry_index <= idx;
    req_ch.red         <= c.red;
    req_ch.green       <= c.green;
    req_ch.blue        <= c.blue;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
  endtask

  task automatic write_entry(slot_t idx, rgb_t c);
    shadow[idx] = c;
    send_item(OP_WRITE, idx, c);
  endtask

  task automatic ask(rgb_t c);
    send_item(OP_QUERY, slot_t'($urandom_range(0, 63)), c);
  endtask

  // Hold the sender until every result is back, then let trailing writes retire.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_active(active_t n);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we    <= 1'b0;
    live = (n > PALETTE_DEPTH) ? PALETTE_DEPTH : n;
  endtask

  // Receiver: random ready, with requested long hold-offs counted here.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end
      rsp_ch.ready <= rsp_calm || ($urandom_range(0, 99) >= 24);
    end
  end

  initial begin
    active_t plan [PHASES];
    plan = '{7'd64, 7'd127, 7'd1, 7'd65, 7'd5, 7'd0, 7'd33, 7'd2, 7'd64, 7'd0, 7'd0, 7'd127};
    plan[9]  = active_t'($urandom_range(1, 127));
    plan[10] = active_t'($urandom_range(1, 64));

    req_ch.valid       <= 1'b0;
    req_ch.op          <= OP_WRITE;
    req_ch.entry_index <= '0;
    req_ch.red         <= '0;
    req_ch.green       <= '0;
    req_ch.blue        <= '0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty search, extremes, ties, largest distance.
    set_active('0);
    send_item(OP_QUERY, '1, WHITE);
    write_entry(6'd0, BLACK);
    write_entry(6'd1, WHITE);
    write_entry(6'd2, BLACK);
    write_entry(6'd3, RED);
    write_entry(6'd63, {8'h55, 8'haa, 8'h0f});
    set_active(7'd1);
    ask(WHITE);
    ask(BLACK);
    set_active(7'd4);
    ask(BLACK);
    ask(WHITE);
    ask({8'd128, 8'd128, 8'd128});
    ask({8'h00, 8'hff, 8'h00});
    ask(RED);
    ask({8'd200, 8'd10, 8'd10});

    // Fill every slot so any search length is legal from here on.
    set_active('0);
    for (int i = 0; i < PALETTE_DEPTH; i++) write_entry(slot_t'(i), pick_color());

    for (int p = 0; p < PHASES; p++) begin
      set_active(plan[p]);
      req_calm = (p == 2 || p == 6 || p == 8);
      rsp_calm <= (p == 6);
      if (p == 2 || p == 8) holds_asked <= holds_asked + 1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 35) begin
          if ($urandom_range(0, 3) == 0)
            write_entry(slot_t'($urandom_range(0, 63)), shadow[$urandom_range(0, 63)]);
          else
            write_entry(slot_t'($urandom_range(0, 63)), pick_color());
        end else begin
          ask(pick_query());
        end
      end
    end

    drain();
    $display("summary: %0d items sent, %0d searches checked, %0d with a nearest entry",
             items_sent, queries_seen, matches_seen);
    $display("summary: %0d search lengths incl. 0, 1, 64 and 127, %0d receiver hold-offs",
             PHASES + 4, holds_done);
    if (mismatches == 0 && awaited == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== nearest_palette_color.f =====
src/npc_pkg.sv
src/npc_if.sv
src/npc_ram.sv
src/npc_front.sv
src/npc_back.sv
src/nearest_palette_color.sv
dv/npc_result_checker.sv
dv/tb.sv
